// ===== rtl/vos_pkg.sv =====
// ----------------------------------------------------------------------------
// vos_pkg
// Shared constants, types, operation codes and index helpers of the operand
// stack engine.
// ----------------------------------------------------------------------------
package vos_pkg;

   // stack geometry; DEPTH may be any value from four up to 127, the largest that stack_depth holds
   localparam int DEPTH     = 64;
   localparam int WORD_W    = 32;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int BANK_BITS = 2;
   localparam int NUM_BANKS = 1 << BANK_BITS;
   localparam int ROWS      = (DEPTH + NUM_BANKS - 1) / NUM_BANKS;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

   // item field widths
   localparam int ACTION_W    = 4;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 7;
   localparam int READ_DATA_W = 32;
   localparam int DEPTH_OUT_W = 7;
   localparam int STATUS_W    = 2;

   // width for depth arithmetic that may go below zero
   localparam int CALC_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

   typedef logic [ACTION_W-1:0]    action_type;
   typedef logic [VALUE_W-1:0]     value_type;
   typedef logic [COUNT_W-1:0]     count_type;
   typedef logic [READ_DATA_W-1:0] read_data_type;
   typedef logic [DEPTH_OUT_W-1:0] depth_out_type;
   typedef logic [STATUS_W-1:0]    status_type;

   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [BANK_BITS-1:0] bank_type;
   typedef logic [ROW_W-1:0]     row_type;
   typedef logic [CALC_W-1:0]    calc_type;

   // operation codes
   localparam action_type ACT_PUSH       = 4'd0;
   localparam action_type ACT_PUSH_UNDER = 4'd1;
   localparam action_type ACT_DUP        = 4'd2;
   localparam action_type ACT_DUP_SECOND = 4'd3;
   localparam action_type ACT_POP        = 4'd4;
   localparam action_type ACT_POP_N      = 4'd5;
   localparam action_type ACT_POP_SECOND = 4'd6;
   localparam action_type ACT_POP_N_KEEP = 4'd7;
   localparam action_type ACT_SWAP       = 4'd8;
   localparam action_type ACT_ROT        = 4'd9;
   localparam action_type ACT_READ       = 4'd10;

   // status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_UNDER = 2'd1;
   localparam status_type ST_OVER  = 2'd2;

   // one write into one bank
   typedef struct packed {
      logic     en;
      row_type  row;
      word_type data;
   } bank_wr_type;

   typedef bank_wr_type [NUM_BANKS-1:0] bank_wr_vec_type;

   // outcome of one operation
   typedef struct packed {
      cnt_type    cnt_next;
      status_type status;
      word_type   data;
   } exec_result_type;

   // absolute index of the entry at depth d below the top
   function automatic idx_type slot_idx(cnt_type cnt, calc_type d);
      calc_type t;
      t = calc_type'(cnt) - d - calc_type'(1);
      return idx_type'(t);
   endfunction

   function automatic bank_type bank_of(idx_type idx);
      return idx[BANK_BITS-1:0];
   endfunction

   function automatic row_type row_of(idx_type idx);
      idx_type t;
      t = idx >> BANK_BITS;
      return row_type'(t);
   endfunction

endpackage

// ===== rtl/vos_if.sv =====
// ----------------------------------------------------------------------------
// vos_req_if / vos_rsp_if
// Valid/ready channels carrying operation items and result items.
// ----------------------------------------------------------------------------
interface vos_req_if;
   logic                  valid;
   logic                  ready;
   vos_pkg::action_type   action;
   vos_pkg::value_type    value;
   vos_pkg::count_type    count;

   modport source (output valid, output action, output value, output count, input ready);
   modport sink   (input valid, input action, input value, input count, output ready);
endinterface

interface vos_rsp_if;
   logic                     valid;
   logic                     ready;
   vos_pkg::read_data_type   read_data;
   vos_pkg::depth_out_type   stack_depth;
   vos_pkg::status_type      status;

   modport source (output valid, output read_data, output stack_depth, output status,
                   input ready);
   modport sink   (input valid, input read_data, input stack_depth, input status,
                   output ready);
endinterface

// ===== rtl/vm_operand_stack_engine_core.sv =====
// ----------------------------------------------------------------------------
// vm_operand_stack_engine_core
// Operand stack of a virtual machine: one stack operation per item, one
// result item per operation.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                               handshake
//   req_ch    in    action, value, count                  valid / ready
//   rsp_ch    out   read_data, stack_depth, status        valid / ready
//
// one item per cycle sustained while results are taken; a result passes
// through the store read at acceptance, the execute stage and the result
// register
// rate is set by the store: four banks interleaved on the entry index, each
// with one write and two reads, so an operation touching three neighboring
// entries plus one at any depth needs only one read of the store
// reset clears the entry count and both valids; the store needs no clearing
// a stalled result holds the execute stage, ready drops only while both the
// execute stage and the result register are full and the result is not taken
//
module vm_operand_stack_engine_core (
   input  logic        clock,
   input  logic        reset,
   vos_req_if.sink     req_ch,
   vos_rsp_if.source   rsp_ch
);

   // execute stage
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   vos_pkg::action_type        s1_action_ff;
   vos_pkg::word_type          s1_value_ff;
   vos_pkg::count_type         s1_n_ff;

   // architectural count
   vos_pkg::cnt_type           count_ff;
   vos_pkg::cnt_type           count_in;

   // result register
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   vos_pkg::read_data_type     rsp_data_ff;
   vos_pkg::depth_out_type     rsp_depth_ff;
   vos_pkg::status_type        rsp_status_ff;

   logic                       adv;
   logic                       req_ready;
   logic                       req_accept;

   vos_pkg::cnt_type           rd_cnt;
   vos_pkg::idx_type           rd_idx [3];
   vos_pkg::row_type           row_a  [vos_pkg::NUM_BANKS];
   vos_pkg::row_type           row_b;

   vos_pkg::word_type          rd_a   [vos_pkg::NUM_BANKS];
   vos_pkg::word_type          rd_b   [vos_pkg::NUM_BANKS];
   vos_pkg::word_type          word_a [vos_pkg::NUM_BANKS];
   vos_pkg::word_type          word_b [vos_pkg::NUM_BANKS];

   // bypass of the write landing on the same edge as the store read
   logic [vos_pkg::NUM_BANKS-1:0] hit_a_ff;
   logic [vos_pkg::NUM_BANKS-1:0] hit_b_ff;
   vos_pkg::word_type             fwd_data_ff [vos_pkg::NUM_BANKS];

   vos_pkg::word_type          r0;
   vos_pkg::word_type          r1;
   vos_pkg::word_type          r2;
   vos_pkg::word_type          rx;

   vos_pkg::bank_wr_vec_type   wr;
   vos_pkg::exec_result_type   ex;

   // handshake
   assign adv        = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ready  = !s1_valid_ff || adv;
   assign req_accept = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   assign count_in     = adv ? ex.cnt_next : count_ff;

   // reads for the new item use the count left by the item ahead of it
   assign rd_cnt = s1_valid_ff ? ex.cnt_next : count_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rd_idx[k] = vos_pkg::slot_idx(rd_cnt, vos_pkg::calc_type'(k));
      end
      // port a: top three entries, one per bank
      for (int b = 0; b < vos_pkg::NUM_BANKS; b++) begin
         row_a[b] = '0;
         for (int k = 0; k < 3; k++) begin
            if (vos_pkg::bank_of(rd_idx[k]) == vos_pkg::bank_type'(b)) begin
               row_a[b] = vos_pkg::row_of(rd_idx[k]);
            end
         end
      end
      // port b: entry at the requested depth
      row_b = vos_pkg::row_of(vos_pkg::slot_idx(rd_cnt, vos_pkg::calc_type'(req_ch.count)));
   end

   // banked entry store
   for (genvar g = 0; g < vos_pkg::NUM_BANKS; g++) begin : g_bank
      vos_bank u_bank (
         .clock (clock),
         .wr    (wr[g]),
         .rd_en (req_accept),
         .row_a (row_a[g]),
         .row_b (row_b),
         .rd_a  (rd_a[g]),
         .rd_b  (rd_b[g])
      );
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int b = 0; b < vos_pkg::NUM_BANKS; b++) begin
            hit_a_ff[b]    <= wr[b].en && (wr[b].row == row_a[b]);
            hit_b_ff[b]    <= wr[b].en && (wr[b].row == row_b);
            fwd_data_ff[b] <= wr[b].data;
         end
      end
   end

   always_comb begin
      for (int b = 0; b < vos_pkg::NUM_BANKS; b++) begin
         word_a[b] = hit_a_ff[b] ? fwd_data_ff[b] : rd_a[b];
         word_b[b] = hit_b_ff[b] ? fwd_data_ff[b] : rd_b[b];
      end
   end

   // operands of the item in the execute stage
   assign r0 = word_a[vos_pkg::bank_of(vos_pkg::slot_idx(count_ff, vos_pkg::calc_type'(0)))];
   assign r1 = word_a[vos_pkg::bank_of(vos_pkg::slot_idx(count_ff, vos_pkg::calc_type'(1)))];
   assign r2 = word_a[vos_pkg::bank_of(vos_pkg::slot_idx(count_ff, vos_pkg::calc_type'(2)))];
   assign rx = word_b[vos_pkg::bank_of(
                  vos_pkg::slot_idx(count_ff, vos_pkg::calc_type'(s1_n_ff)))];

   vos_exec u_exec (
      .fire   (adv),
      .action (s1_action_ff),
      .value  (s1_value_ff),
      .n      (s1_n_ff),
      .cnt    (count_ff),
      .r0     (r0),
      .r1     (r1),
      .r2     (r2),
      .rx     (rx),
      .wr     (wr),
      .res    (ex)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff <= req_ch.action;
         s1_value_ff  <= vos_pkg::word_type'(req_ch.value);
         s1_n_ff      <= req_ch.count;
      end
      if (adv) begin
         rsp_data_ff   <= vos_pkg::read_data_type'(ex.data);
         rsp_depth_ff  <= vos_pkg::depth_out_type'(ex.cnt_next);
         rsp_status_ff <= ex.status;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_data   = rsp_data_ff;
   assign rsp_ch.stack_depth = rsp_depth_ff;
   assign rsp_ch.status      = rsp_status_ff;

   // count moves only when an item completes
   a_count_hold : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(count_ff))
      else $error("entry count changed without a completing item");

   // a refused operation leaves the count alone
   a_refused_hold : assert property (@(posedge clock) disable iff (reset)
      adv && (ex.status != vos_pkg::ST_OK) |=> (count_ff == $past(count_ff)))
      else $error("refused operation changed the entry count");

   // overflow is only reported on a full stack
   a_over_full : assert property (@(posedge clock) disable iff (reset)
      adv && (ex.status == vos_pkg::ST_OVER)
         |-> (count_ff == vos_pkg::cnt_type'(vos_pkg::DEPTH)))
      else $error("overflow reported on a stack that is not full");

endmodule

// ===== rtl/vos_bank.sv =====
// ----------------------------------------------------------------------------
// vos_bank
// One bank of the stack store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module vos_bank (
   input  logic                  clock,
   input  vos_pkg::bank_wr_type  wr,
   input  logic                  rd_en,
   input  vos_pkg::row_type      row_a,
   input  vos_pkg::row_type      row_b,
   output vos_pkg::word_type     rd_a,
   output vos_pkg::word_type     rd_b
);

   vos_pkg::word_type mem [vos_pkg::ROWS];
   vos_pkg::word_type rd_a_ff;
   vos_pkg::word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.row] <= wr.data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[row_a];
         rd_b_ff <= mem[row_b];
      end
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

// ===== rtl/vos_exec.sv =====
// ----------------------------------------------------------------------------
// vos_exec
// Checks and carries out one stack operation: new count, status, result word
// and the entry writes, spread over the banks.
// ----------------------------------------------------------------------------
module vos_exec (
   input  logic                       fire,
   input  vos_pkg::action_type        action,
   input  vos_pkg::word_type          value,
   input  vos_pkg::count_type         n,
   input  vos_pkg::cnt_type           cnt,
   input  vos_pkg::word_type          r0,
   input  vos_pkg::word_type          r1,
   input  vos_pkg::word_type          r2,
   input  vos_pkg::word_type          rx,
   output vos_pkg::bank_wr_vec_type   wr,
   output vos_pkg::exec_result_type   res
);

   vos_pkg::calc_type  need;
   vos_pkg::calc_type  c;
   vos_pkg::calc_type  nc;
   logic               add;
   logic               under;
   logic               over;
   logic               ok;
   vos_pkg::idx_type   idx0;
   vos_pkg::idx_type   idx1;
   vos_pkg::idx_type   idx2;
   vos_pkg::idx_type   idxn;
   vos_pkg::idx_type   idxp;
   logic               cand_en   [3];
   vos_pkg::idx_type   cand_idx  [3];
   vos_pkg::word_type  cand_data [3];

   assign c    = vos_pkg::calc_type'(cnt);
   assign idx0 = vos_pkg::slot_idx(cnt, vos_pkg::calc_type'(0));
   assign idx1 = vos_pkg::slot_idx(cnt, vos_pkg::calc_type'(1));
   assign idx2 = vos_pkg::slot_idx(cnt, vos_pkg::calc_type'(2));
   assign idxn = vos_pkg::slot_idx(cnt, vos_pkg::calc_type'(n));
   assign idxp = vos_pkg::idx_type'(cnt);

   // entries needed and whether one is added
   always_comb begin
      need = '0;
      add  = 1'b0;
      unique case (action)
         vos_pkg::ACT_PUSH: begin
            add = 1'b1;
         end
         vos_pkg::ACT_PUSH_UNDER, vos_pkg::ACT_DUP: begin
            need = vos_pkg::calc_type'(1);
            add  = 1'b1;
         end
         vos_pkg::ACT_DUP_SECOND: begin
            need = vos_pkg::calc_type'(2);
            add  = 1'b1;
         end
         vos_pkg::ACT_POP: begin
            need = vos_pkg::calc_type'(1);
         end
         vos_pkg::ACT_POP_N: begin
            need = vos_pkg::calc_type'(n);
         end
         vos_pkg::ACT_POP_SECOND, vos_pkg::ACT_SWAP: begin
            need = vos_pkg::calc_type'(2);
         end
         vos_pkg::ACT_POP_N_KEEP, vos_pkg::ACT_READ: begin
            need = vos_pkg::calc_type'(n) + vos_pkg::calc_type'(1);
         end
         vos_pkg::ACT_ROT: begin
            need = vos_pkg::calc_type'(3);
         end
         default: begin
         end
      endcase
   end

   // underflow is checked before overflow
   assign under = c < need;
   assign over  = add && (cnt == vos_pkg::cnt_type'(vos_pkg::DEPTH));
   assign ok    = !under && !over;

   always_comb begin
      nc = c;
      if (ok) begin
         unique case (action)
            vos_pkg::ACT_PUSH, vos_pkg::ACT_PUSH_UNDER,
            vos_pkg::ACT_DUP, vos_pkg::ACT_DUP_SECOND: begin
               nc = c + vos_pkg::calc_type'(1);
            end
            vos_pkg::ACT_POP, vos_pkg::ACT_POP_SECOND: begin
               nc = c - vos_pkg::calc_type'(1);
            end
            vos_pkg::ACT_POP_N, vos_pkg::ACT_POP_N_KEEP: begin
               nc = c - vos_pkg::calc_type'(n);
            end
            default: begin
            end
         endcase
      end
   end

   // result word: the read entry, else the top after the operation
   always_comb begin
      res.cnt_next = vos_pkg::cnt_type'(nc);
      res.status   = under ? vos_pkg::ST_UNDER : (over ? vos_pkg::ST_OVER : vos_pkg::ST_OK);
      res.data     = r0;
      if (ok) begin
         unique case (action)
            vos_pkg::ACT_PUSH:                        res.data = value;
            vos_pkg::ACT_DUP_SECOND, vos_pkg::ACT_POP,
            vos_pkg::ACT_SWAP:                        res.data = r1;
            vos_pkg::ACT_ROT:                         res.data = r2;
            vos_pkg::ACT_POP_N, vos_pkg::ACT_READ:    res.data = rx;
            default:                                  res.data = r0;
         endcase
      end
      if (nc == '0) begin
         res.data = '0;
      end
   end

   // up to three entry writes; their indexes always fall in different banks
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cand_en[k]   = 1'b0;
         cand_idx[k]  = '0;
         cand_data[k] = '0;
      end
      if (fire && ok) begin
         unique case (action)
            vos_pkg::ACT_PUSH: begin
               cand_en[0] = 1'b1; cand_idx[0] = idxp; cand_data[0] = value;
            end
            vos_pkg::ACT_PUSH_UNDER: begin
               cand_en[0] = 1'b1; cand_idx[0] = idx0; cand_data[0] = value;
               cand_en[1] = 1'b1; cand_idx[1] = idxp; cand_data[1] = r0;
            end
            vos_pkg::ACT_DUP: begin
               cand_en[0] = 1'b1; cand_idx[0] = idxp; cand_data[0] = r0;
            end
            vos_pkg::ACT_DUP_SECOND: begin
               cand_en[0] = 1'b1; cand_idx[0] = idxp; cand_data[0] = r1;
            end
            vos_pkg::ACT_POP_SECOND: begin
               cand_en[0] = 1'b1; cand_idx[0] = idx1; cand_data[0] = r0;
            end
            vos_pkg::ACT_POP_N_KEEP: begin
               cand_en[0] = 1'b1; cand_idx[0] = idxn; cand_data[0] = r0;
            end
            vos_pkg::ACT_SWAP: begin
               cand_en[0] = 1'b1; cand_idx[0] = idx0; cand_data[0] = r1;
               cand_en[1] = 1'b1; cand_idx[1] = idx1; cand_data[1] = r0;
            end
            vos_pkg::ACT_ROT: begin
               cand_en[0] = 1'b1; cand_idx[0] = idx0; cand_data[0] = r2;
               cand_en[1] = 1'b1; cand_idx[1] = idx1; cand_data[1] = r0;
               cand_en[2] = 1'b1; cand_idx[2] = idx2; cand_data[2] = r1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int b = 0; b < vos_pkg::NUM_BANKS; b++) begin
         wr[b] = '0;
         for (int k = 0; k < 3; k++) begin
            if (cand_en[k] && (vos_pkg::bank_of(cand_idx[k]) == vos_pkg::bank_type'(b))) begin
               wr[b].en   = 1'b1;
               wr[b].row  = vos_pkg::row_of(cand_idx[k]);
               wr[b].data = cand_data[k];
            end
         end
      end
   end

endmodule

// ===== verif/tb_vm_operand_stack_engine_core.sv =====
// ----------------------------------------------------------------------------
// tb_vm_operand_stack_engine_core
// Self-checking bench for the operand stack engine. A short table of directed
// operations walks the empty, small and error cases, then bursts of random
// operations grow, drain and abuse the stack. Every accepted operation runs
// through a behavioral stack kept in the bench, and each result item is
// compared field by field with the oldest expected result: a row's golden where set, else the prediction.
// ----------------------------------------------------------------------------
module tb_vm_operand_stack_engine_core;

   // unused operation codes run from just above read up to the last one
   localparam vos_pkg::action_type ACT_UNUSED_FIRST =
      vos_pkg::action_type'(vos_pkg::ACT_READ + 4'd1);
   localparam vos_pkg::action_type ACT_UNUSED_LAST  = 4'd15;
   localparam vos_pkg::count_type  COUNT_MAX        = 7'd127;

   localparam int NUM_DIRECTED = 25;
   localparam int RANDOM_OPS   = 1600;
   localparam int STALL_LIMIT  = 1000;   // cycles with no handshake on either side
   localparam int DRAIN_CYCLES = 8;      // two-stage pipe plus margin

   // one result item as the block reports it
   typedef struct packed {
      vos_pkg::read_data_type read_data;
      vos_pkg::depth_out_type stack_depth;
      vos_pkg::status_type    status;
   } stack_result_type;

   // one directed operation; golden is used only where has_golden is set
   typedef struct packed {
      vos_pkg::action_type action;
      vos_pkg::value_type  value;
      vos_pkg::count_type  count;
      logic                has_golden;
      stack_result_type    golden;
   } stim_row_type;

   typedef enum {MIX_GROW, MIX_SHRINK, MIX_ANY, MIX_NOISE} traffic_mode_type;

   logic clock = 1'b0;
   logic reset;

   vos_req_if req_ch ();
   vos_rsp_if rsp_ch ();

   vm_operand_stack_engine_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // behavioral stack: entries bottom first, stack_cnt entries live
   // ---------------------------------------------------------------------------
   vos_pkg::word_type stack_mem [vos_pkg::DEPTH];
   int                stack_cnt = 0;

   stack_result_type  expected_q [$];
   int                mismatch_count = 0;

   // golden value riding along with the item currently offered
   logic              drive_has_golden;
   stack_result_type  drive_golden;

   stim_row_type      directed_rows [NUM_DIRECTED];

   // apply one operation to the behavioral stack and return its result item
   function automatic stack_result_type apply_stack_op(vos_pkg::action_type act,
                                                       vos_pkg::value_type val,
                                                       vos_pkg::count_type cnt);
      int                need;
      bit                grows;
      bit                is_read;
      int                top;
      vos_pkg::word_type tmp;
      stack_result_type  res;
      need    = 0;
      grows   = 1'b0;
      is_read = 1'b0;
      res     = '0;
      case (act)
         vos_pkg::ACT_PUSH:                   grows = 1'b1;
         vos_pkg::ACT_PUSH_UNDER, vos_pkg::ACT_DUP: begin
            need  = 1;
            grows = 1'b1;
         end
         vos_pkg::ACT_DUP_SECOND: begin
            need  = 2;
            grows = 1'b1;
         end
         vos_pkg::ACT_POP:                    need = 1;
         vos_pkg::ACT_POP_N:                  need = int'(cnt);
         vos_pkg::ACT_POP_SECOND, vos_pkg::ACT_SWAP: need = 2;
         vos_pkg::ACT_POP_N_KEEP:             need = int'(cnt) + 1;
         vos_pkg::ACT_ROT:                    need = 3;
         vos_pkg::ACT_READ: begin
            need    = int'(cnt) + 1;
            is_read = 1'b1;
         end
         default: ;                  // unused codes leave everything alone
      endcase

      // the underflow check wins over the overflow check
      if (stack_cnt < need) begin
         res.status = vos_pkg::ST_UNDER;
      end else if (grows && stack_cnt >= vos_pkg::DEPTH) begin
         res.status = vos_pkg::ST_OVER;
      end else begin
         res.status = vos_pkg::ST_OK;
         top = stack_cnt - 1;
         case (act)
            vos_pkg::ACT_PUSH: begin
               stack_mem[stack_cnt] = val;
               stack_cnt++;
            end
            vos_pkg::ACT_PUSH_UNDER: begin
               tmp                  = stack_mem[top];
               stack_mem[top]       = val;
               stack_mem[stack_cnt] = tmp;
               stack_cnt++;
            end
            vos_pkg::ACT_DUP: begin
               stack_mem[stack_cnt] = stack_mem[top];
               stack_cnt++;
            end
            vos_pkg::ACT_DUP_SECOND: begin
               stack_mem[stack_cnt] = stack_mem[top-1];
               stack_cnt++;
            end
            vos_pkg::ACT_POP:        stack_cnt--;
            vos_pkg::ACT_POP_N:      stack_cnt -= int'(cnt);
            vos_pkg::ACT_POP_SECOND: begin
               stack_mem[top-1] = stack_mem[top];
               stack_cnt--;
            end
            vos_pkg::ACT_POP_N_KEEP: begin
               stack_mem[top-int'(cnt)] = stack_mem[top];
               stack_cnt -= int'(cnt);
            end
            vos_pkg::ACT_SWAP: begin
               tmp              = stack_mem[top];
               stack_mem[top]   = stack_mem[top-1];
               stack_mem[top-1] = tmp;
            end
            vos_pkg::ACT_ROT: begin
               // top takes third, second takes old top, third takes old second
               tmp              = stack_mem[top];
               stack_mem[top]   = stack_mem[top-2];
               stack_mem[top-2] = stack_mem[top-1];
               stack_mem[top-1] = tmp;
            end
            default: ;
         endcase
      end

      // a failed read reports the top word like any other operation
      if (is_read && res.status == vos_pkg::ST_OK)
         res.read_data = stack_mem[stack_cnt-1-int'(cnt)];
      else if (stack_cnt == 0)
         res.read_data = '0;
      else
         res.read_data = stack_mem[stack_cnt-1];
      res.stack_depth = vos_pkg::depth_out_type'(stack_cnt);
      return res;
   endfunction

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // monitor: results are checked before the item of the same edge is added,
   // a result can never belong to the item taken at the same edge
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      stack_result_type got_res;
      stack_result_type want_res;
      stack_result_type pred_res;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_res = '{rsp_ch.read_data, rsp_ch.stack_depth, rsp_ch.status};
            if (expected_q.size() == 0) begin
               $display("%0t: result item with none expected, actual %0h/%0d/%0d",
                        $time, got_res.read_data, got_res.stack_depth, got_res.status);
               mismatch_count++;
            end else begin
               want_res = expected_q.pop_front();
               compare_field("read_data", want_res.read_data, got_res.read_data);
               compare_field("stack_depth", 32'(want_res.stack_depth),
                             32'(got_res.stack_depth));
               compare_field("status", 32'(want_res.status), 32'(got_res.status));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            // the behavioral stack always advances, even on table rows
            pred_res = apply_stack_op(req_ch.action, req_ch.value, req_ch.count);
            expected_q.push_back(drive_has_golden ? drive_golden : pred_res);
         end
      end
   end

   // watchdog: counts cycles in which neither channel moves an item
   int stall_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // receiver: stall pattern changes mode after a random run, and a couple
   // of long hold-offs let the pipe fill so the block must drop req ready
   // ---------------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int unsigned rx_cycle;
      int unsigned mode_left;
      int unsigned hold_left;
      int unsigned rx_mode;
      rsp_ch.ready = 1'b0;
      rx_cycle     = 0;
      mode_left    = 0;
      hold_left    = 0;
      rx_mode      = 0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (rx_cycle == 600 || rx_cycle == 2500)
            hold_left = $urandom_range(80, 150);
         if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            mode_left = $urandom_range(16, 80);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (rx_mode)
               0:       rsp_ch.ready <= 1'b1;                          // no stalls
               1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
               2:       rsp_ch.ready <= ($urandom_range(0, 9) < 3);
               default: rsp_ch.ready <= rx_cycle[0];                   // every other
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // sender
   // ---------------------------------------------------------------------------

   // called at a falling edge: put one item on the channel, hold until taken
   task automatic offer_item(vos_pkg::action_type act, vos_pkg::value_type val,
                             vos_pkg::count_type cnt, logic has_golden,
                             stack_result_type golden);
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.value     <= val;
      req_ch.count     <= cnt;
      drive_has_golden <= has_golden;
      drive_golden     <= golden;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // random operation, shaped by the traffic mode and the current stack depth
   task automatic pick_op(traffic_mode_type mode, output vos_pkg::action_type act,
                          output vos_pkg::value_type val,
                          output vos_pkg::count_type cnt);
      int unsigned roll;
      int unsigned vroll;
      roll  = $urandom_range(0, 99);
      vroll = $urandom_range(0, 9);
      case (mode)
         MIX_GROW:
            act = (roll < 88)
               ? vos_pkg::action_type'($urandom_range(vos_pkg::ACT_PUSH,
                                                      vos_pkg::ACT_DUP_SECOND))
               : vos_pkg::action_type'($urandom_range(vos_pkg::ACT_POP,
                                                      vos_pkg::ACT_READ));
         MIX_SHRINK:
            act = (roll < 60)
               ? vos_pkg::action_type'($urandom_range(vos_pkg::ACT_POP,
                                                      vos_pkg::ACT_POP_N_KEEP))
               : vos_pkg::action_type'($urandom_range(vos_pkg::ACT_PUSH,
                                                      vos_pkg::ACT_READ));
         MIX_ANY:
            act = vos_pkg::action_type'($urandom_range(vos_pkg::ACT_PUSH,
                                                       vos_pkg::ACT_READ));
         default: begin
            // unused codes, or counted operations with counts past the stack
            if (roll < 50)
               act = vos_pkg::action_type'($urandom_range(ACT_UNUSED_FIRST,
                                                          ACT_UNUSED_LAST));
            else if (roll < 67)
               act = vos_pkg::ACT_POP_N;
            else if (roll < 84)
               act = vos_pkg::ACT_POP_N_KEEP;
            else
               act = vos_pkg::ACT_READ;
         end
      endcase
      if (vroll == 0)
         val = '0;
      else if (vroll == 1)
         val = '1;
      else
         val = vos_pkg::value_type'($urandom);
      if (mode == MIX_NOISE)
         cnt = vos_pkg::count_type'($urandom_range(vos_pkg::DEPTH + 1, COUNT_MAX));
      else if ($urandom_range(0, 9) == 0)
         cnt = vos_pkg::count_type'($urandom_range(0, COUNT_MAX));
      else
         cnt = vos_pkg::count_type'($urandom_range(0, stack_cnt));
   endtask

   initial begin
      int                  ops_done;
      int unsigned         burst_len;
      int unsigned         gap_len;
      int unsigned         mode_roll;
      traffic_mode_type    mode;
      vos_pkg::action_type act;
      vos_pkg::value_type  val;
      vos_pkg::count_type  cnt;

      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.action    = vos_pkg::ACT_PUSH;
      req_ch.value     = '0;
      req_ch.count     = '0;
      drive_has_golden = 1'b0;
      drive_golden     = '0;

      // directed table; golden typed in only where it is plain from the spec
      directed_rows = '{
         // empty stack: underflow, zero counts and an unused code
         '{vos_pkg::ACT_POP,        32'h0, 7'd0, 1'b1, '{32'h0, 7'd0, vos_pkg::ST_UNDER}},
         '{vos_pkg::ACT_READ,       32'h0, 7'd0, 1'b1, '{32'h0, 7'd0, vos_pkg::ST_UNDER}},
         '{vos_pkg::ACT_POP_N,      32'h0, 7'd0, 1'b1, '{32'h0, 7'd0, vos_pkg::ST_OK}},
         '{vos_pkg::ACT_POP_N_KEEP, 32'h0, 7'd0, 1'b1, '{32'h0, 7'd0, vos_pkg::ST_UNDER}},
         '{ACT_UNUSED_LAST, 32'hFFFF_FFFF, 7'd127, 1'b1,
           '{32'h0, 7'd0, vos_pkg::ST_OK}},
         // value extremes
         '{vos_pkg::ACT_PUSH, 32'hFFFF_FFFF, 7'd0, 1'b1,
           '{32'hFFFF_FFFF, 7'd1, vos_pkg::ST_OK}},
         '{vos_pkg::ACT_PUSH, 32'h0, 7'd127, 1'b1, '{32'h0, 7'd2, vos_pkg::ST_OK}},
         // every operation on a small stack
         '{vos_pkg::ACT_SWAP,       32'h0,         7'd0,   1'b0, '0},
         '{vos_pkg::ACT_PUSH_UNDER, 32'hA5A5_A5A5, 7'd0,   1'b0, '0},
         '{vos_pkg::ACT_DUP,        32'h0,         7'd0,   1'b0, '0},
         '{vos_pkg::ACT_DUP_SECOND, 32'h0,         7'd0,   1'b0, '0},
         '{vos_pkg::ACT_PUSH,       32'h5A5A_5A5A, 7'd0,   1'b0, '0},
         '{vos_pkg::ACT_ROT,        32'h0,         7'd0,   1'b0, '0},
         '{vos_pkg::ACT_READ,       32'h0,         7'd2,   1'b0, '0},
         '{vos_pkg::ACT_READ,       32'h0,         7'd64,  1'b0, '0},
         '{vos_pkg::ACT_READ,       32'h0,         7'd127, 1'b0, '0},
         '{vos_pkg::ACT_POP_SECOND, 32'h0,         7'd0,   1'b0, '0},
         '{vos_pkg::ACT_POP_N_KEEP, 32'h0,         7'd2,   1'b0, '0},
         '{vos_pkg::ACT_POP_N,      32'h0,         7'd0,   1'b0, '0},
         '{vos_pkg::ACT_POP_N,      32'h0,         7'd127, 1'b0, '0},
         '{ACT_UNUSED_FIRST,        32'h1234_5678, 7'd5,   1'b0, '0},
         '{vos_pkg::ACT_POP_N_KEEP, 32'h0,         7'd1,   1'b0, '0},
         '{vos_pkg::ACT_POP,        32'h0,         7'd0,   1'b0, '0},
         '{vos_pkg::ACT_ROT,        32'h0,         7'd0,   1'b0, '0},
         '{vos_pkg::ACT_POP_N,      32'h0,         7'd64,  1'b0, '0}
      };

      // synchronous reset, released on a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         @(negedge clock);
         offer_item(directed_rows[i].action, directed_rows[i].value,
                    directed_rows[i].count, directed_rows[i].has_golden,
                    directed_rows[i].golden);
      end

      // random bursts; items of unused codes do not count toward the total
      ops_done = 0;
      while (ops_done < RANDOM_OPS) begin
         mode_roll = $urandom_range(0, 99);
         if (mode_roll < 35)
            mode = MIX_GROW;
         else if (mode_roll < 65)
            mode = MIX_SHRINK;
         else if (mode_roll < 92)
            mode = MIX_ANY;
         else
            mode = MIX_NOISE;
         burst_len = $urandom_range(1, 24);
         gap_len   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         repeat (burst_len) begin
            // pick after the falling edge so the stack depth is up to date
            @(negedge clock);
            pick_op(mode, act, val, cnt);
            offer_item(act, val, cnt, 1'b0, '0);
            if (act <= vos_pkg::ACT_READ)
               ops_done++;
         end
         if (gap_len != 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap_len - 1) @(negedge clock);
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;

      // drain outstanding results, then keep watching for stray ones
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/vos_pkg.sv
rtl/vos_if.sv
rtl/vos_bank.sv
rtl/vos_exec.sv
rtl/vm_operand_stack_engine_core.sv
verif/tb_vm_operand_stack_engine_core.sv
